[rtl/dec_pkg.sv]
// Shared types, widths and fixed-point helpers for the disc collision pipeline.
// Used by every module of the block; depends on nothing.
package dec_pkg;

  // Fraction bits of the unit normal, the mass weights and the overlap.
  localparam int FRAC = 28;

  // The square root makes one result bit per stage.
  localparam int SQRT_STAGES = 34;

  // The dividers make one quotient bit per stage.
  localparam int DIV_STAGES = 29;

  // Number of register stages in the bounce arithmetic.
  localparam int BNC_STAGES = 7;

  // Q1.28 constants used for the mass weights.
  localparam logic [29:0] ONE_Q28 = 30'h1000_0000;
  localparam logic [28:0] HALF_Q28 = 29'h0800_0000;

  // Data that travels beside the square root and the dividers.
  typedef struct packed {
    logic               hit;
    logic signed [32:0] rx;
    logic signed [32:0] ry;
    logic [33:0]        rsum;
    logic [31:0]        ma;
    logic [33:0]        msum;
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
  } side_t;

  // Operands of the bounce arithmetic once the normal and weights are known.
  typedef struct packed {
    logic               hit;
    logic signed [32:0] rx;
    logic signed [32:0] ry;
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic signed [29:0] nx;
    logic signed [29:0] ny;
    logic [28:0]        ov;
    logic [28:0]        wa;
    logic [28:0]        wb;
  } bounce_t;

  // One finished result word.
  typedef struct packed {
    logic        hit;
    logic [31:0] nvax;
    logic [31:0] nvay;
    logic [31:0] nvbx;
    logic [31:0] nvby;
    logic [31:0] fax;
    logic [31:0] fay;
    logic [31:0] fbx;
    logic [31:0] fby;
  } result_t;

  // Arithmetic right shift that rounds toward zero.
  function automatic logic signed [71:0] tdz(input logic signed [71:0] x,
                                             input int unsigned k);
    logic signed [71:0] bias;
    bias = x[71] ? ((72'sd1 <<< k) - 72'sd1) : 72'sd0;
    return (x + bias) >>> k;
  endfunction

  // Clamp to the 32-bit signed range.
  function automatic logic [31:0] sat32(input logic signed [71:0] x);
    logic [31:0] r;
    if (x > 72'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -72'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/disc_elastic_collision.sv]
// Top level of the two-disc elastic collision pipeline.
// Depends on dec_pkg, dec_sqrt, dec_div, dec_bounce and dec_out.

// Takes one disc pair per clock cycle while the pipeline is not stalled and returns
// one result word per pair, in order. The depth comes from the front stages for the
// differences, squares and overlap test, the 34-stage pipelined square root of the
// squared distance, 29-stage dividers for the unit normal, the overlap and the mass
// weights, seven stages of multiply and round, and the output register. A hit flag
// on tuser says the discs overlapped; without a hit the velocities come back unchanged
// and the corrections are zero. An output skid entry lets a stall on the result side
// hold the pipeline without losing a word.
module disc_elastic_collision (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_a_x, pos_a_y, vel_a_x, vel_a_y, mass_a, radius_a,
  // pos_b_x, pos_b_y, vel_b_x, vel_b_y, mass_b, radius_b (32 bits each)
  input  logic [383:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y,
  // fix_a_x, fix_a_y, fix_b_x, fix_b_y (32 bits each)
  output logic [255:0] m_axis_tdata,
  // hit
  output logic         m_axis_tuser
);

  logic ce;

  logic signed [31:0] in_pax, in_pay, in_vax, in_vay, in_pbx, in_pby, in_vbx, in_vby;
  logic [31:0]        in_ma, in_ra, in_mb, in_rb;

  assign in_pax = s_axis_tdata[31:0];
  assign in_pay = s_axis_tdata[63:32];
  assign in_vax = s_axis_tdata[95:64];
  assign in_vay = s_axis_tdata[127:96];
  assign in_ma  = s_axis_tdata[159:128];
  assign in_ra  = s_axis_tdata[191:160];
  assign in_pbx = s_axis_tdata[223:192];
  assign in_pby = s_axis_tdata[255:224];
  assign in_vbx = s_axis_tdata[287:256];
  assign in_vby = s_axis_tdata[319:288];
  assign in_mb  = s_axis_tdata[351:320];
  assign in_rb  = s_axis_tdata[383:352];

  assign s_axis_tready = ce;

  // Front stages: differences, squares, overlap test.
  logic               v1, v2, v3;
  dec_pkg::side_t     f1, f2, f3;
  dec_pkg::side_t     f2h;
  logic [32:0]        mrx1, mry1;
  logic [65:0]        sqx2, sqy2;
  logic [67:0]        rr2;
  logic [66:0]        ssum;
  logic [65:0]        s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (ce) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign mrx1 = f1.rx[32] ? 33'(-f1.rx) : 33'(f1.rx);
  assign mry1 = f1.ry[32] ? 33'(-f1.ry) : 33'(f1.ry);
  assign ssum = 67'(sqx2) + 67'(sqy2);

  // Side data of stage two with the overlap test filled in.
  always_comb begin
    f2h     = f2;
    f2h.hit = (ssum != 67'd0) && (68'(ssum) <= rr2);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f1.hit  <= 1'b0;
      f1.rx   <= 33'(in_pbx) - 33'(in_pax);
      f1.ry   <= 33'(in_pby) - 33'(in_pay);
      f1.rsum <= 34'(in_ra) + 34'(in_rb);
      f1.ma   <= in_ma;
      f1.msum <= 34'(in_ma) + 34'(in_mb);
      f1.vax  <= in_vax;
      f1.vay  <= in_vay;
      f1.vbx  <= in_vbx;
      f1.vby  <= in_vby;

      f2   <= f1;
      sqx2 <= 66'(mrx1) * 66'(mrx1);
      sqy2 <= 66'(mry1) * 66'(mry1);
      rr2  <= 68'(f1.rsum) * 68'(f1.rsum);

      f3 <= f2h;
      s3 <= ssum[65:0];
    end
  end

  // Square root of the squared distance, with side data delayed alongside.
  logic [33:0]    root;
  dec_pkg::side_t sq_d [0:dec_pkg::SQRT_STAGES-1];
  logic [dec_pkg::SQRT_STAGES-1:0] sq_v;

  dec_sqrt u_sqrt (
    .clk  (clk),
    .ce   (ce),
    .rad  (s3),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= '0;
    end else if (ce) begin
      sq_v <= {sq_v[dec_pkg::SQRT_STAGES-2:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sq_d[0] <= f3;
      for (int i = 1; i < dec_pkg::SQRT_STAGES; i++) begin
        sq_d[i] <= sq_d[i-1];
      end
    end
  end

  // Normal, overlap and weight divisions run side by side.
  dec_pkg::side_t sd;
  logic [33:0]    num_x, num_y, num_o;
  logic [28:0]    qx, qy, qo, qw;
  logic [33:0]    rx_unused, ry_unused, ro_unused, rw;

  assign sd    = sq_d[dec_pkg::SQRT_STAGES-1];
  assign num_x = sd.rx[32] ? 34'(33'(-sd.rx)) : 34'(33'(sd.rx));
  assign num_y = sd.ry[32] ? 34'(33'(-sd.ry)) : 34'(33'(sd.ry));
  assign num_o = sd.rsum - root;

  dec_div u_div_x (
    .clk (clk), .ce (ce), .num (num_x), .den (root), .quo (qx), .rem (rx_unused)
  );
  dec_div u_div_y (
    .clk (clk), .ce (ce), .num (num_y), .den (root), .quo (qy), .rem (ry_unused)
  );
  dec_div u_div_o (
    .clk (clk), .ce (ce), .num (num_o), .den (sd.rsum), .quo (qo), .rem (ro_unused)
  );
  dec_div u_div_w (
    .clk (clk), .ce (ce), .num (34'(sd.ma)), .den (sd.msum), .quo (qw), .rem (rw)
  );

  dec_pkg::side_t dv_d [0:dec_pkg::DIV_STAGES-1];
  logic [dec_pkg::DIV_STAGES-1:0] dv_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v <= '0;
    end else if (ce) begin
      dv_v <= {dv_v[dec_pkg::DIV_STAGES-2:0], sq_v[dec_pkg::SQRT_STAGES-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dv_d[0] <= sd;
      for (int i = 1; i < dec_pkg::DIV_STAGES; i++) begin
        dv_d[i] <= dv_d[i-1];
      end
    end
  end

  // Signs of the normal, and the second weight from the first one's remainder.
  dec_pkg::side_t     sf;
  dec_pkg::bounce_t   bin;
  logic signed [29:0] nxm, nym;
  logic               mzero;
  logic [29:0]        wb_full;

  assign sf      = dv_d[dec_pkg::DIV_STAGES-1];
  assign nxm     = $signed({1'b0, qx});
  assign nym     = $signed({1'b0, qy});
  assign mzero   = sf.msum == 34'd0;
  assign wb_full = dec_pkg::ONE_Q28 - 30'(qw) - 30'(rw != 34'd0);

  always_comb begin
    bin.hit = sf.hit;
    bin.rx  = sf.rx;
    bin.ry  = sf.ry;
    bin.vax = sf.vax;
    bin.vay = sf.vay;
    bin.vbx = sf.vbx;
    bin.vby = sf.vby;
    bin.nx  = sf.rx[32] ? -nxm : nxm;
    bin.ny  = sf.ry[32] ? -nym : nym;
    bin.ov  = qo;
    bin.wa  = mzero ? dec_pkg::HALF_Q28 : qw;
    bin.wb  = mzero ? dec_pkg::HALF_Q28 : wb_full[28:0];
  end

  // Velocity exchange and corrections.
  logic             bnc_valid;
  dec_pkg::result_t bnc_data;
  dec_pkg::result_t res;

  dec_bounce u_bounce (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (dv_v[dec_pkg::DIV_STAGES-1]),
    .in_data   (bin),
    .out_valid (bnc_valid),
    .out_data  (bnc_data)
  );

  dec_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bnc_valid),
    .in_data   (bnc_data),
    .ce        (ce),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tuser = res.hit;
  assign m_axis_tdata = {res.fby, res.fbx, res.fay, res.fax,
                         res.nvby, res.nvbx, res.nvay, res.nvax};

endmodule

[rtl/dec_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Uses dec_pkg for the stage count.
module dec_sqrt (
  input  logic        clk,
  input  logic        ce,
  input  logic [65:0] rad,
  output logic [33:0] root
);

  logic [65:0] rem_q [0:dec_pkg::SQRT_STAGES-1];
  logic [33:0] res_q [0:dec_pkg::SQRT_STAGES-1];

  for (genvar j = 0; j < dec_pkg::SQRT_STAGES; j++) begin : g_stage
    localparam int K = dec_pkg::SQRT_STAGES - 1 - j;
    logic [65:0] rem_in;
    logic [33:0] res_in;
    logic [67:0] trial;

    if (j == 0) begin : g_first
      assign rem_in = rad;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign res_in = res_q[j-1];
    end

    // (res + 2^K)^2 - res^2; res holds only bits above K, so OR is the add.
    assign trial = (68'(res_in) << (K + 1)) | (68'd1 << (2 * K));

    // Keep the bit when the remainder covers the trial value.
    always_ff @(posedge clk) begin
      if (ce) begin
        if (68'(rem_in) >= trial) begin
          rem_q[j] <= rem_in - trial[65:0];
          res_q[j] <= res_in | (34'd1 << K);
        end else begin
          rem_q[j] <= rem_in;
          res_q[j] <= res_in;
        end
      end
    end
  end

  assign root = res_q[dec_pkg::SQRT_STAGES-1];

endmodule

[rtl/dec_div.sv]
// Pipelined restoring divider for num <= den, giving a 29-bit quotient.
// Uses dec_pkg for the stage count.
module dec_div (
  input  logic        clk,
  input  logic        ce,
  input  logic [33:0] num,
  input  logic [33:0] den,
  output logic [28:0] quo,
  output logic [33:0] rem
);

  logic [34:0] rem_q [0:dec_pkg::DIV_STAGES-1];
  logic [33:0] den_q [0:dec_pkg::DIV_STAGES-1];
  logic [28:0] quo_q [0:dec_pkg::DIV_STAGES-1];

  for (genvar j = 0; j < dec_pkg::DIV_STAGES; j++) begin : g_stage
    logic [34:0] rem_in;
    logic [33:0] den_in;
    logic [28:0] quo_in;
    logic        ge;

    if (j == 0) begin : g_first
      assign rem_in = {1'b0, num};
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = {rem_q[j-1][33:0], 1'b0};
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign ge = rem_in >= {1'b0, den_in};

    // One compare and subtract per stage.
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[j] <= ge ? (rem_in - {1'b0, den_in}) : rem_in;
        den_q[j] <= den_in;
        quo_q[j] <= {quo_in[27:0], ge};
      end
    end
  end

  assign quo = quo_q[dec_pkg::DIV_STAGES-1];
  assign rem = rem_q[dec_pkg::DIV_STAGES-1][33:0];

endmodule

[rtl/dec_bounce.sv]
// Velocity exchange along the centre line and position corrections, seven stages.
// Uses dec_pkg for the operand types and the rounding and clamping helpers.
module dec_bounce (
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  logic                in_valid,
  input  dec_pkg::bounce_t    in_data,
  output logic                out_valid,
  output dec_pkg::result_t    out_data
);

  logic [dec_pkg::BNC_STAGES-1:0] vld;

  dec_pkg::bounce_t b1, b2, b3, b4, b5, b6;

  logic signed [61:0] pvax1, pvay1, pvbx1, pvby1;
  logic [57:0]        pco1;
  logic signed [34:0] van2, vbn2;
  logic signed [29:0] cora2, corb2;
  logic signed [35:0] dv3;
  logic signed [62:0] pfax3, pfay3, pfbx3, pfby3;
  logic signed [65:0] pa4, pb4;
  logic signed [34:0] fax4, fay4, fbx4, fby4;
  logic signed [34:0] fax5, fay5, fbx5, fby5;
  logic signed [34:0] fax6, fay6, fbx6, fby6;
  logic signed [37:0] ca5, cb5;
  logic signed [67:0] qax6, qay6, qbx6, qby6;
  logic signed [29:0] cora_c;

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[dec_pkg::BNC_STAGES-2:0], in_valid};
    end
  end

  assign cora_c = -$signed(30'(pco1 >> dec_pkg::FRAC));

  always_ff @(posedge clk) begin
    if (ce) begin
      // Stage 1: velocity dot normal products and the overlap weight.
      b1    <= in_data;
      pvax1 <= in_data.vax * in_data.nx;
      pvay1 <= in_data.vay * in_data.ny;
      pvbx1 <= in_data.vbx * in_data.nx;
      pvby1 <= in_data.vby * in_data.ny;
      pco1  <= 58'(in_data.ov) * 58'(in_data.wb);

      // Stage 2: normal speeds and correction factors.
      b2    <= b1;
      van2  <= 35'(dec_pkg::tdz(72'(pvax1) + 72'(pvay1), dec_pkg::FRAC));
      vbn2  <= 35'(dec_pkg::tdz(72'(pvbx1) + 72'(pvby1), dec_pkg::FRAC));
      cora2 <= cora_c;
      corb2 <= cora_c + $signed({1'b0, b1.ov});

      // Stage 3: relative normal speed and correction products.
      b3    <= b2;
      dv3   <= 36'(van2) - 36'(vbn2);
      pfax3 <= b2.rx * cora2;
      pfay3 <= b2.ry * cora2;
      pfbx3 <= b2.rx * corb2;
      pfby3 <= b2.ry * corb2;

      // Stage 4: weighted speed change and corrections.
      b4   <= b3;
      pa4  <= $signed({1'b0, b3.wb}) * dv3;
      pb4  <= $signed({1'b0, b3.wa}) * dv3;
      fax4 <= 35'(dec_pkg::tdz(72'(pfax3), dec_pkg::FRAC));
      fay4 <= 35'(dec_pkg::tdz(72'(pfay3), dec_pkg::FRAC));
      fbx4 <= 35'(dec_pkg::tdz(72'(pfbx3), dec_pkg::FRAC));
      fby4 <= 35'(dec_pkg::tdz(72'(pfby3), dec_pkg::FRAC));

      // Stage 5: doubled weight scaling of the speed change.
      b5   <= b4;
      ca5  <= 38'(dec_pkg::tdz(72'(pa4), dec_pkg::FRAC - 1));
      cb5  <= 38'(dec_pkg::tdz(72'(pb4), dec_pkg::FRAC - 1));
      fax5 <= fax4;
      fay5 <= fay4;
      fbx5 <= fbx4;
      fby5 <= fby4;

      // Stage 6: speed change back onto the axes.
      b6   <= b5;
      qax6 <= ca5 * b5.nx;
      qay6 <= ca5 * b5.ny;
      qbx6 <= cb5 * b5.nx;
      qby6 <= cb5 * b5.ny;
      fax6 <= fax5;
      fay6 <= fay5;
      fbx6 <= fbx5;
      fby6 <= fby5;

      // Stage 7: new velocities, clamping, and the no-hit pass-through.
      out_data.hit <= b6.hit;
      if (b6.hit) begin
        out_data.nvax <= dec_pkg::sat32(72'(b6.vax) - dec_pkg::tdz(72'(qax6), dec_pkg::FRAC));
        out_data.nvay <= dec_pkg::sat32(72'(b6.vay) - dec_pkg::tdz(72'(qay6), dec_pkg::FRAC));
        out_data.nvbx <= dec_pkg::sat32(72'(b6.vbx) + dec_pkg::tdz(72'(qbx6), dec_pkg::FRAC));
        out_data.nvby <= dec_pkg::sat32(72'(b6.vby) + dec_pkg::tdz(72'(qby6), dec_pkg::FRAC));
        out_data.fax  <= dec_pkg::sat32(72'(fax6));
        out_data.fay  <= dec_pkg::sat32(72'(fay6));
        out_data.fbx  <= dec_pkg::sat32(72'(fbx6));
        out_data.fby  <= dec_pkg::sat32(72'(fby6));
      end else begin
        out_data.nvax <= b6.vax;
        out_data.nvay <= b6.vay;
        out_data.nvbx <= b6.vbx;
        out_data.nvby <= b6.vby;
        out_data.fax  <= '0;
        out_data.fay  <= '0;
        out_data.fbx  <= '0;
        out_data.fby  <= '0;
      end
    end
  end

  assign out_valid = vld[dec_pkg::BNC_STAGES-1];

endmodule

[rtl/dec_out.sv]
// Output register with one skid entry; its fullness gates the whole pipeline.
// Uses dec_pkg for the result word type.
module dec_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  dec_pkg::result_t in_data,
  output logic             ce,
  output logic             out_valid,
  input  logic             out_ready,
  output dec_pkg::result_t out_data
);

  logic             skid_valid;
  dec_pkg::result_t skid_data;
  logic             take;

  // The pipeline advances whenever the skid entry is free.
  assign ce   = ~skid_valid;
  assign take = in_valid & ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload follows the same choice as the valid bits.
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (take) begin
      skid_data <= in_data;
    end
  end

endmodule
